FILE: sv/sm4_pkg.sv
// ----------------------------------------------------------------------------
// sm4_pkg: shared types, constants and functions
// s-box, system parameters, round constants and the two linear transforms
// ----------------------------------------------------------------------------
`default_nettype none
package sm4_pkg;

    localparam int RoundCount = 32;
    localparam int RkAw       = $clog2(RoundCount);

    typedef enum logic [2:0] {
        CFG_KEY_HIGH = 3'd0,
        CFG_KEY_LOW  = 3'd1,
        CFG_IV_HIGH  = 3'd2,
        CFG_IV_LOW   = 3'd3,
        CFG_MODE     = 3'd4,
        CFG_DIR      = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        MODE_ECB = 3'd0,
        MODE_CBC = 3'd1,
        MODE_CFB = 3'd2,
        MODE_OFB = 3'd3,
        MODE_CTR = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEXP,
        ST_LOAD,
        ST_RUN,
        ST_DONE
    } t_state;

    // control from top to the round engine
    typedef struct packed {
        logic             start;
        logic             kexp;
        logic             dec;
    } t_eng_ctl;

    typedef struct packed {
        logic             busy;
        logic             done;
    } t_eng_sts;

    localparam logic [31:0] Fk0 = 32'hA3B1BAC6;
    localparam logic [31:0] Fk1 = 32'h56AA3350;
    localparam logic [31:0] Fk2 = 32'h677D9197;
    localparam logic [31:0] Fk3 = 32'hB27022DC;

    localparam logic [7:0] Sbox [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    function automatic logic [31:0] sub_word(input logic [31:0] x);
        sub_word = {Sbox[x[31:24]], Sbox[x[23:16]], Sbox[x[15:8]], Sbox[x[7:0]]};
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

    // byte j of constant i is (4i+j)*7 mod 256
    function automatic logic [31:0] round_const(input logic [RkAw-1:0] i);
        logic [7:0] b0;
        b0 = 8'({i, 2'b00}) * 8'd7;
        round_const = {b0, b0 + 8'd7, b0 + 8'd14, b0 + 8'd21};
    endfunction

    function automatic logic [31:0] lin_enc(input logic [31:0] b);
        lin_enc = b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
    endfunction

    function automatic logic [31:0] lin_key(input logic [31:0] b);
        lin_key = b ^ rotl(b, 13) ^ rotl(b, 23);
    endfunction

endpackage
`default_nettype wire

FILE: sv/sm4_if.sv
// ----------------------------------------------------------------------------
// sm4 channel interfaces
// data in, data out and configuration write channels
// ----------------------------------------------------------------------------
`default_nettype none
interface sm4_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic [4:0]  valid_bytes;
    logic        first_block;
    modport source (output valid, block_high, block_low, valid_bytes, first_block,
                    input ready);
    modport sink   (input valid, block_high, block_low, valid_bytes, first_block,
                    output ready);
endinterface

interface sm4_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_high;
    logic [63:0] result_low;
    logic [4:0]  result_bytes;
    modport source (output valid, result_high, result_low, result_bytes, input ready);
    modport sink   (input valid, result_high, result_low, result_bytes, output ready);
endinterface

interface sm4_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: sv/sm4_rk_ram.sv
// ----------------------------------------------------------------------------
// sm4_rk_ram: round key memory
// 32 x 32 single write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none
module sm4_rk_ram
    import sm4_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire logic [RkAw-1:0] i_waddr,
    input  wire logic [31:0]     i_wdata,
    input  wire logic [RkAw-1:0] i_raddr,
    output logic      [31:0]     o_rdata
);
    logic [31:0] r_mem [RoundCount];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: sv/sm4_engine.sv
// ----------------------------------------------------------------------------
// sm4_engine: shared round unit
// key expansion writes the key memory; cipher rounds read it one per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module sm4_engine
    import sm4_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_eng_ctl     i_ctl,
    input  wire logic [127:0] i_din,
    output t_eng_sts          o_sts,
    output logic      [127:0] o_dout
);
    logic [31:0]     r_x [4];
    logic [31:0]     n_x [4];
    logic [RkAw:0]   r_cnt, n_cnt;
    logic            r_busy, n_busy;
    logic            r_kexp, n_kexp;
    logic            r_dec, n_dec;
    logic            r_done, n_done;
    logic            r_rdv, n_rdv;
    logic [RkAw-1:0] raddr;
    logic [31:0]     rk;
    logic [31:0]     tin, tb, nx;
    logic            we;

    sm4_rk_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_cnt[RkAw-1:0]),
        .i_wdata (nx),
        .i_raddr (raddr),
        .o_rdata (rk)
    );

    // read address runs one ahead of the round that uses it
    always_comb begin
        logic [RkAw-1:0] idx;
        idx   = (i_ctl.start || !r_rdv) ? '0 : RkAw'(r_cnt[RkAw-1:0] + 1'b1);
        raddr = (i_ctl.start ? i_ctl.dec : r_dec) ? ~idx : idx;
    end

    always_comb begin
        tin = r_kexp ? (r_x[1] ^ r_x[2] ^ r_x[3] ^ round_const(r_cnt[RkAw-1:0]))
                     : (r_x[1] ^ r_x[2] ^ r_x[3] ^ rk);
        tb  = sub_word(tin);
        nx  = r_x[0] ^ (r_kexp ? lin_key(tb) : lin_enc(tb));
        we  = r_busy && r_kexp;
    end

    always_comb begin
        n_x    = r_x;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_kexp = r_kexp;
        n_dec  = r_dec;
        n_done = 1'b0;
        n_rdv  = r_rdv;
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_kexp = i_ctl.kexp;
            n_dec  = i_ctl.dec;
            n_cnt  = '0;
            n_rdv  = 1'b0;
            if (i_ctl.kexp) begin
                n_x[0] = i_din[127:96] ^ Fk0;
                n_x[1] = i_din[95:64]  ^ Fk1;
                n_x[2] = i_din[63:32]  ^ Fk2;
                n_x[3] = i_din[31:0]   ^ Fk3;
            end else begin
                n_x[0] = i_din[127:96];
                n_x[1] = i_din[95:64];
                n_x[2] = i_din[63:32];
                n_x[3] = i_din[31:0];
            end
        end else if (r_busy && !r_kexp && !r_rdv) begin
            // first key read in flight
            n_rdv = 1'b1;
        end else if (r_busy) begin
            n_x[0] = r_x[1];
            n_x[1] = r_x[2];
            n_x[2] = r_x[3];
            n_x[3] = nx;
            n_cnt  = r_cnt + 1'b1;
            if (r_cnt == (RkAw+1)'(RoundCount - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_kexp <= 1'b0;
            r_dec  <= 1'b0;
            r_rdv  <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
            r_kexp <= n_kexp;
            r_dec  <= n_dec;
            r_rdv  <= n_rdv;
        end
        r_x <= n_x;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_dout     = {r_x[3], r_x[2], r_x[1], r_x[0]};

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("done while busy");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> !r_busy) else $error("start while busy");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt < (RkAw+1)'(RoundCount)) else $error("round count overrun");
endmodule
`default_nettype wire

FILE: sv/sm4_cipher_with_block_modes.sv
// ----------------------------------------------------------------------------
// sm4_cipher_with_block_modes: SM4 with ECB, CBC, CFB, OFB and CTR
// one block in, one block out, keys held in a round key memory
// ----------------------------------------------------------------------------
// One block at a time. A block that needs the cipher passes through a load,
// one key memory read, 32 rounds of the shared round unit, a step to take
// the round unit result and an output step. A short ECB/CBC block skips the
// round unit. After a key write the next block first runs a key expansion
// through the same round unit into the round key memory.
`default_nettype none
module sm4_cipher_with_block_modes
    import sm4_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sm4_cfg_if.sink   cfg,
    sm4_in_if.sink    din,
    sm4_out_if.source dout
);
    logic [63:0]  r_key_hi, r_key_lo, r_iv_hi, r_iv_lo;
    logic [2:0]   r_mode;
    logic         r_dir;
    logic         r_kready, n_kready;
    logic [127:0] r_chain, n_chain;
    logic [127:0] r_data, n_data;
    logic [127:0] r_mask, n_mask;
    logic [4:0]   r_cnt, n_cnt;
    logic         r_first, n_first;
    logic [127:0] r_res, n_res;
    logic [4:0]   r_rbytes, n_rbytes;
    logic         r_ovalid, n_ovalid;
    t_state       r_state, n_state;
    t_eng_ctl     ectl;
    t_eng_sts     ests;
    logic [127:0] edin, edout;
    t_mode        mode;
    logic         full, use_ks, dec;

    assign cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi <= '0;
            r_key_lo <= '0;
            r_iv_hi  <= '0;
            r_iv_lo  <= '0;
            r_mode   <= '0;
            r_dir    <= 1'b0;
        end else if (cfg.valid) begin
            case (cfg.index)
                CFG_KEY_HIGH: r_key_hi <= cfg.data;
                CFG_KEY_LOW:  r_key_lo <= cfg.data;
                CFG_IV_HIGH:  r_iv_hi  <= cfg.data;
                CFG_IV_LOW:   r_iv_lo  <= cfg.data;
                CFG_MODE:     r_mode   <= cfg.data[2:0];
                CFG_DIR:      r_dir    <= cfg.data[0];
                default: ;
            endcase
        end
    end

    sm4_engine u_eng (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ectl),
        .i_din   (edin),
        .o_sts   (ests),
        .o_dout  (edout)
    );

    assign mode   = (r_mode > 3'd4) ? MODE_ECB : t_mode'(r_mode);
    assign full   = (r_cnt == 5'd16);
    assign use_ks = !(mode == MODE_ECB || mode == MODE_CBC);
    assign dec    = r_dir && !use_ks;

    assign din.ready = (r_state == ST_IDLE) && !r_ovalid;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (din.valid && din.ready) n_state = r_kready ? ST_LOAD : ST_KEXP;
            ST_KEXP: if (ests.done) n_state = ST_LOAD;
            ST_LOAD: n_state = (!full && !use_ks) ? ST_DONE : ST_RUN;
            ST_RUN:  if (ests.done) n_state = ST_DONE;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // engine control and datapath
    always_comb begin
        logic [127:0] ks, o;
        ectl     = '0;
        edin     = {r_key_hi, r_key_lo};
        n_kready = r_kready;
        n_chain  = r_chain;
        n_data   = r_data;
        n_mask   = r_mask;
        n_cnt    = r_cnt;
        n_first  = r_first;
        n_res    = r_res;
        n_rbytes = r_rbytes;
        n_ovalid = r_ovalid && !dout.ready;
        ks       = edout;
        o        = '0;
        if (cfg.valid && (cfg.index == CFG_KEY_HIGH || cfg.index == CFG_KEY_LOW)) begin
            n_kready = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (din.valid && din.ready) begin
                    n_cnt   = (din.valid_bytes > 5'd16) ? 5'd16 : din.valid_bytes;
                    n_mask  = ~(128'(~128'd0) >> {n_cnt, 3'b000});
                    n_data  = {din.block_high, din.block_low} & n_mask;
                    n_first = din.first_block;
                    if (!r_kready) begin
                        ectl.start = 1'b1;
                        ectl.kexp  = 1'b1;
                    end
                end
            end
            ST_KEXP: begin
                if (ests.done) n_kready = 1'b1;
            end
            ST_LOAD: begin
                if (r_first) n_chain = {r_iv_hi, r_iv_lo};
                if (full || use_ks) begin
                    ectl.start = 1'b1;
                    ectl.dec   = dec;
                    if (use_ks) edin = n_chain;
                    else if (mode == MODE_CBC && !dec) edin = r_data ^ n_chain;
                    else edin = r_data;
                end
            end
            ST_RUN: begin
                if (ests.done) begin
                    if (use_ks) begin
                        o = (r_data ^ ks) & r_mask;
                        if (full) begin
                            case (mode)
                                MODE_CFB: n_chain = r_dir ? r_data : o;
                                MODE_OFB: n_chain = ks;
                                MODE_CTR: n_chain = r_chain + 128'd1;
                                default: ;
                            endcase
                        end
                    end else if (mode == MODE_CBC) begin
                        if (dec) begin
                            o       = ks ^ r_chain;
                            n_chain = r_data;
                        end else begin
                            o       = ks;
                            n_chain = ks;
                        end
                    end else begin
                        o = ks;
                    end
                    n_res = o;
                end
            end
            ST_DONE: begin
                if (!full && !use_ks) n_res = r_data;
                n_rbytes = r_cnt;
                n_ovalid = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_kready <= 1'b0;
            r_chain  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_kready <= n_kready;
            r_chain  <= n_chain;
            r_ovalid <= n_ovalid;
        end
        r_data   <= n_data;
        r_mask   <= n_mask;
        r_cnt    <= n_cnt;
        r_first  <= n_first;
        r_res    <= n_res;
        r_rbytes <= n_rbytes;
    end

    assign dout.valid        = r_ovalid;
    assign dout.result_high  = r_res[127:64];
    assign dout.result_low   = r_res[63:0];
    assign dout.result_bytes = r_rbytes;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (din.valid && din.ready) |-> !ests.busy) else $error("accept while engine busy");
    a_run_engine: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && $past(r_state) == ST_RUN) |-> ests.busy || ests.done)
        else $error("run without engine");
    a_kexp_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_KEXP && ests.done && !cfg.valid) |=> r_kready)
        else $error("keys not marked ready");
endmodule
`default_nettype wire

FILE: sim/sm4_cipher_with_block_modes_tb.sv
// ----------------------------------------------------------------------------
// sm4_cipher_with_block_modes_tb: self-checking bench for the sm4 block modes
// drives blocks under random key, iv, mode and direction settings and checks
// every result beat against a predictor of the cipher and its chaining state
// ----------------------------------------------------------------------------
`default_nettype none
module sm4_cipher_with_block_modes_tb;
    import sm4_pkg::*;

    localparam int WatchdogLimit = 20000;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
        logic [4:0]  nbytes;
    } t_blk_res;

    class sm4_scoreboard;
        logic [63:0] key_hi, key_lo, iv_hi, iv_lo;
        logic [2:0]  mode;
        logic        dir;
        logic [31:0] rkeys [RoundCount];
        logic        rk_valid;
        logic [63:0] ch_hi, ch_lo;
        t_blk_res    pending [$];
        int          errors;

        function new();
            key_hi = '0; key_lo = '0; iv_hi = '0; iv_lo = '0;
            mode = '0; dir = 1'b0; rk_valid = 1'b0;
            ch_hi = '0; ch_lo = '0; errors = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [63:0] val);
            case (idx)
                CFG_KEY_HIGH: begin key_hi = val; rk_valid = 1'b0; end
                CFG_KEY_LOW:  begin key_lo = val; rk_valid = 1'b0; end
                CFG_IV_HIGH:  iv_hi = val;
                CFG_IV_LOW:   iv_lo = val;
                CFG_MODE:     mode = val[2:0];
                CFG_DIR:      dir = val[0];
                default: ;
            endcase
        endfunction

        function logic [31:0] tau(logic [31:0] x);
            logic [7:0] sb [256];
            sb = '{
            8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
            8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
            8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
            8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
            8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
            8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
            8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
            8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
            8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
            8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
            8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
            8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
            8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
            8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
            8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
            8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
            };
            return {sb[x[31:24]], sb[x[23:16]], sb[x[15:8]], sb[x[7:0]]};
        endfunction

        function logic [31:0] rol(logic [31:0] x, int n);
            return (x << n) | (x >> (32 - n));
        endfunction

        function void expand();
            logic [31:0] k [4];
            logic [31:0] b, ck, nk;
            logic [7:0]  cb;
            k[0] = key_hi[63:32] ^ 32'hA3B1BAC6;
            k[1] = key_hi[31:0]  ^ 32'h56AA3350;
            k[2] = key_lo[63:32] ^ 32'h677D9197;
            k[3] = key_lo[31:0]  ^ 32'hB27022DC;
            for (int i = 0; i < RoundCount; i++) begin
                for (int j = 0; j < 4; j++) begin
                    cb = 8'((4 * i + j) * 7);
                    ck = {ck[23:0], cb};
                end
                b  = tau(k[1] ^ k[2] ^ k[3] ^ ck);
                nk = k[0] ^ b ^ rol(b, 13) ^ rol(b, 23);
                rkeys[i] = nk;
                k[0] = k[1]; k[1] = k[2]; k[2] = k[3]; k[3] = nk;
            end
            rk_valid = 1'b1;
        endfunction

        function logic [127:0] crypt(logic [127:0] blk, logic decrypt);
            logic [31:0] x0, x1, x2, x3, b, nx;
            {x0, x1, x2, x3} = blk;
            for (int r = 0; r < RoundCount; r++) begin
                b  = tau(x1 ^ x2 ^ x3 ^ rkeys[decrypt ? RoundCount - 1 - r : r]);
                nx = x0 ^ b ^ rol(b, 2) ^ rol(b, 10) ^ rol(b, 18) ^ rol(b, 24);
                x0 = x1; x1 = x2; x2 = x3; x3 = nx;
            end
            return {x3, x2, x1, x0};
        endfunction

        // predict one block and advance the chaining register
        function void note_block(logic [63:0] bhi, logic [63:0] blo, logic [4:0] vb,
                                 logic first);
            logic [127:0] msk, din, dout, ks, chn;
            int           n;
            logic [2:0]   m;
            t_blk_res     r;
            if (!rk_valid) expand();
            if (first) begin ch_hi = iv_hi; ch_lo = iv_lo; end
            n = (vb > 16) ? 16 : vb;
            m = (mode > MODE_CTR) ? MODE_ECB : mode;
            msk = (n == 0) ? '0 : ~(128'h0) << (128 - 8 * n);
            din = {bhi, blo} & msk;
            chn = {ch_hi, ch_lo};
            dout = din;
            if (m == MODE_ECB || m == MODE_CBC) begin
                if (n == 16 && m == MODE_ECB) dout = crypt(din, dir);
                else if (n == 16 && !dir) begin
                    dout = crypt(din ^ chn, 1'b0);
                    chn = dout;
                end else if (n == 16) begin
                    dout = crypt(din, 1'b1) ^ chn;
                    chn = din;
                end
            end else begin
                ks = crypt(chn, 1'b0);
                dout = (din ^ ks) & msk;
                if (n == 16) begin
                    if (m == MODE_CFB) chn = dir ? din : dout;
                    else if (m == MODE_OFB) chn = ks;
                    else chn = chn + 128'd1;
                end
            end
            {ch_hi, ch_lo} = chn;
            r.hi = dout[127:64]; r.lo = dout[63:0]; r.nbytes = 5'(n);
            pending.push_back(r);
        endfunction

        function void check_result(logic [63:0] hi, logic [63:0] lo, logic [4:0] nb);
            t_blk_res e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h %h %0d", $time, hi, lo, nb);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (e.hi !== hi) begin
                $display("%0t: result_high expected %h actual %h", $time, e.hi, hi);
                errors++;
            end
            if (e.lo !== lo) begin
                $display("%0t: result_low expected %h actual %h", $time, e.lo, lo);
                errors++;
            end
            if (e.nbytes !== nb) begin
                $display("%0t: result_bytes expected %0d actual %0d", $time, e.nbytes, nb);
                errors++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n;
    sm4_cfg_if cfg ();
    sm4_in_if  din ();
    sm4_out_if dout ();

    sm4_cipher_with_block_modes DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .cfg     (cfg.sink),
        .din     (din.sink),
        .dout    (dout.source)
    );

    sm4_scoreboard sb;
    int  idle_cnt;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // result side: random stall, sampled at the rising edge
    initial begin
        int stall;
        dout.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            dout.ready = 1'b0;
            repeat (stall) @(negedge i_clk);
            dout.ready = 1'b1;
            @(posedge i_clk iff dout.valid);
            sb.check_result(dout.result_high, dout.result_low, dout.result_bytes);
        end
    end

    // watchdog on cycles with no accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (din.valid && din.ready) || (dout.valid && dout.ready)
                || (cfg.valid && cfg.ready)) begin
            idle_cnt <= 0;
        end else begin
            idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= WatchdogLimit) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic write_cfg(t_cfg_idx idx, logic [63:0] val);
        @(negedge i_clk);
        cfg.valid = 1'b1;
        cfg.index = idx;
        cfg.data  = val;
        @(posedge i_clk iff cfg.ready);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        cfg.valid = 1'b0;
    endtask

    // wait until every expected beat has come back, then let the engine settle
    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic setup(logic [63:0] khi, logic [63:0] klo, logic [63:0] ihi,
                         logic [63:0] ilo, logic [2:0] m, logic d);
        drain();
        write_cfg(CFG_KEY_HIGH, khi);
        write_cfg(CFG_KEY_LOW, klo);
        write_cfg(CFG_IV_HIGH, ihi);
        write_cfg(CFG_IV_LOW, ilo);
        write_cfg(CFG_MODE, 64'(m));
        write_cfg(CFG_DIR, 64'(d));
    endtask

    task automatic send_block(logic [63:0] bhi, logic [63:0] blo, logic [4:0] vb,
                              logic first);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        repeat (gap) @(negedge i_clk);
        @(negedge i_clk);
        din.valid       = 1'b1;
        din.block_high  = bhi;
        din.block_low   = blo;
        din.valid_bytes = vb;
        din.first_block = first;
        @(posedge i_clk iff din.ready);
        sb.note_block(bhi, blo, vb, first);
        @(negedge i_clk);
        din.valid = 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly full blocks, occasionally short or oversized counts
    function automatic logic [4:0] rand_count();
        int p;
        p = $urandom_range(0, 9);
        if (p < 7) return 5'd16;
        if (p < 9) return 5'($urandom_range(0, 15));
        return 5'($urandom_range(17, 31));
    endfunction

    initial begin
        logic [2:0] m;
        int nmsg;
        sb = new();
        i_rst_n = 1'b0;
        cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
        din.valid = 1'b0; din.block_high = '0; din.block_low = '0;
        din.valid_bytes = '0; din.first_block = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // standard vector in ecb, then decrypt it back
        setup(64'h0123456789abcdef, 64'hfedcba9876543210, '0, '0, MODE_ECB, 1'b0);
        send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 5'd16, 1'b1);
        send_block('1, '1, 5'd16, 1'b0);
        send_block('0, '0, 5'd0, 1'b0);
        send_block('1, '1, 5'd31, 1'b0);
        send_block('1, '1, 5'd7, 1'b0);
        setup(64'h0123456789abcdef, 64'hfedcba9876543210, '1, '1, MODE_ECB, 1'b1);
        send_block(64'h681edf34d206965e, 64'h86b3e94f536e4246, 5'd16, 1'b1);
        // each mode with a short tail; ctr counter wraps from all ones
        for (int i = MODE_CBC; i <= 7; i++) begin
            setup(rand64(), rand64(), '1, '1, 3'(i), 1'(i & 1));
            send_block(rand64(), rand64(), 5'd16, 1'b1);
            send_block(rand64(), rand64(), 5'd16, 1'b0);
            send_block(rand64(), rand64(), 5'(i + 3), 1'b0);
        end

        // random messages with occasional noise of stray first flags
        for (int ph = 0; ph < 14; ph++) begin
            m = 3'($urandom_range(0, 7));
            setup(rand64(), rand64(), rand64(), rand64(), m, 1'($urandom));
            for (int k = 0; k < 96; k++) begin
                nmsg = (k == 0) || ($urandom_range(0, 15) == 0);
                send_block(rand64(), rand64(), rand_count(), 1'(nmsg));
            end
        end
        drain();
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire
